@@ src/vrtb_pkg.sv @@
// Shared types and constants for the voice release timer bank.
// Used by vrtb_ctrl, vrtb_dpath and voice_release_timer_bank_unit; depends on nothing.
package vrtb_pkg;

  localparam int unsigned PadCount = 2;
  localparam int unsigned FramesW  = 32;
  localparam int unsigned RateW    = 18;
  localparam int unsigned SourceW  = 8;
  localparam int unsigned VoiceW   = 4;
  localparam int unsigned CfgDataW = 18;
  localparam int unsigned QFracW   = 16;
  localparam int unsigned ProdW    = FramesW + RateW;

  // Item kinds; the fourth code means no operation.
  localparam logic [1:0] KIND_SCHEDULE = 2'd0;
  localparam logic [1:0] KIND_CLEAR    = 2'd1;
  localparam logic [1:0] KIND_ADVANCE  = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_SAMPLE_RATE = 2'd0;
  localparam logic [1:0] REG_FIRST_SRC   = 2'd1;
  localparam logic [1:0] REG_SECOND_SRC  = 2'd2;
  localparam logic [1:0] REG_RELEASE_EN  = 2'd3;

  localparam logic [RateW-1:0]   RATE_RESET       = 18'd48000;
  localparam logic [SourceW-1:0] FIRST_SRC_RESET  = 8'd1;
  localparam logic [SourceW-1:0] SECOND_SRC_RESET = 8'd2;
  localparam logic               RELEASE_EN_RESET = 1'b1;

  typedef struct packed {
    logic accept;
    logic exec;
    logic walk;
    logic flush;
  } dp_cmd_t;

  typedef struct packed {
    logic adv_go;
    logic walk_end;
  } dp_status_t;

endpackage

@@ src/voice_release_timer_bank_unit.sv @@
// Top level of the voice release timer bank: a bank of frame countdowns.
// Instantiates vrtb_ctrl and vrtb_dpath; depends on vrtb_pkg.
//
// An item is taken when start is high and busy is low. Schedule, clear and
// no-operation items, and an advance that finds release switched off or no
// elapsed frames, keep busy high only while the controller is in its EXEC
// state. Any other advance item walks the countdown table one entry per
// cycle through a single compare-and-subtract unit, every entry of both
// pads in turn, and then keeps busy high through the FLUSH state.
// Results come from an output register: each one is shown for exactly one
// cycle with result_valid_o high and cannot be held off, so the receiver
// must take it in that cycle. Every item gives at least one result, and the
// final one of an item carries last_o. A note-off is delivered one hit late
// so that the final expiry can be flagged, which means the last result of an
// advance appears in the first cycle in which busy is low again.
// The hold time is multiplied by the sample rate in the cycle the item is
// taken and registered before the frame count is clamped and written.
// Configuration writes are always accepted and must only be issued while the
// block is idle.
module voice_release_timer_bank_unit import vrtb_pkg::*; #(
  parameter int unsigned NUM_VOICES = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic [1:0]          kind_i,
  input  logic [1:0]          pad_number_i,
  input  logic [VoiceW-1:0]   voice_number_i,
  input  logic [FramesW-1:0]  hold_time_q16_i,
  input  logic [SourceW-1:0]  clear_source_i,
  input  logic [FramesW-1:0]  elapsed_frames_i,
  output logic                result_valid_o,
  output logic                fired_o,
  output logic                fired_pad_o,
  output logic [VoiceW-1:0]   fired_voice_o,
  output logic                last_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // Registers are plain flops, so a write is never refused.
  assign cfg_ready_o = 1'b1;

  vrtb_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  vrtb_dpath #(
    .NUM_VOICES (NUM_VOICES)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .cfg_we_i         (cfg_valid_i && cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .kind_i           (kind_i),
    .pad_number_i     (pad_number_i),
    .voice_number_i   (voice_number_i),
    .hold_time_q16_i  (hold_time_q16_i),
    .clear_source_i   (clear_source_i),
    .elapsed_frames_i (elapsed_frames_i),
    .result_valid_o   (result_valid_o),
    .fired_o          (fired_o),
    .fired_pad_o      (fired_pad_o),
    .fired_voice_o    (fired_voice_o),
    .last_o           (last_o)
  );

`ifndef ASSERT_OFF
  // Every item ends with a final result just as the block goes idle.
  a_end_has_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> (result_valid_o && last_o))
    else $error("block went idle without a final result");

  // An accepted item always makes the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted item did not start work");

  // A result that is not a note-off is always the only, hence final, one.
  a_plain_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !fired_o) |-> last_o)
    else $error("plain result without last flag");

  // A note-off names a voice that exists.
  a_voice_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && fired_o) |-> ({1'b0, fired_voice_o} < (VoiceW+1)'(NUM_VOICES)))
    else $error("note-off for a voice out of range");
`endif

endmodule

@@ src/vrtb_ctrl.sv @@
// Controller state machine of the voice release timer bank.
// Depends on vrtb_pkg for the command and status structs.
module vrtb_ctrl import vrtb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o,
  output logic       busy_o
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_EXEC  = 4'b0010,
    ST_WALK  = 4'b0100,
    ST_FLUSH = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign accept = start_i && (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = status_i.adv_go ? ST_WALK : ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = ST_IDLE;
      end
      ST_WALK: begin
        if (status_i.walk_end) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign cmd_o.accept = accept;
  assign cmd_o.exec   = (state_q == ST_EXEC);
  assign cmd_o.walk   = (state_q == ST_WALK);
  assign cmd_o.flush  = (state_q == ST_FLUSH);
  assign busy_o       = (state_q != ST_IDLE);

endmodule

@@ src/vrtb_dpath.sv @@
// Datapath of the voice release timer bank: configuration, countdown table,
// hold-time multiplier, walk counter and result register. Depends on vrtb_pkg.
module vrtb_dpath import vrtb_pkg::*; #(
  parameter int unsigned NUM_VOICES = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dp_cmd_t             cmd_i,
  output dp_status_t          status_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic [1:0]          kind_i,
  input  logic [1:0]          pad_number_i,
  input  logic [VoiceW-1:0]   voice_number_i,
  input  logic [FramesW-1:0]  hold_time_q16_i,
  input  logic [SourceW-1:0]  clear_source_i,
  input  logic [FramesW-1:0]  elapsed_frames_i,
  output logic                result_valid_o,
  output logic                fired_o,
  output logic                fired_pad_o,
  output logic [VoiceW-1:0]   fired_voice_o,
  output logic                last_o
);

  localparam int unsigned VW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam logic [VW-1:0] LastVoice = VW'(NUM_VOICES - 1);

  // Configuration registers.
  logic [RateW-1:0]   rate_q;
  logic [SourceW-1:0] first_src_q, second_src_q;
  logic               rel_en_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q       <= RATE_RESET;
      first_src_q  <= FIRST_SRC_RESET;
      second_src_q <= SECOND_SRC_RESET;
      rel_en_q     <= RELEASE_EN_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_SAMPLE_RATE: rate_q       <= cfg_data_i[RateW-1:0];
        REG_FIRST_SRC:   first_src_q  <= cfg_data_i[SourceW-1:0];
        REG_SECOND_SRC:  second_src_q <= cfg_data_i[SourceW-1:0];
        REG_RELEASE_EN:  rel_en_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Captured item and the registered hold-time product.
  logic [1:0]         kind_q;
  logic [1:0]         pad_q;
  logic [VoiceW-1:0]  voice_q;
  logic [SourceW-1:0] src_q;
  logic [FramesW-1:0] elapsed_q;
  logic [ProdW-1:0]   prod_q, prod_d;

  assign prod_d = {{RateW{1'b0}}, hold_time_q16_i} * {{FramesW{1'b0}}, rate_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      kind_q    <= kind_i;
      pad_q     <= pad_number_i;
      voice_q   <= voice_number_i;
      src_q     <= clear_source_i;
      elapsed_q <= elapsed_frames_i;
      prod_q    <= prod_d;
    end
  end

  assign status_o.adv_go = (kind_i == KIND_ADVANCE) && rel_en_q
                           && (elapsed_frames_i != '0);

  // Frame count from the product: the Q16 fraction is dropped, then the
  // count is saturated at the top and raised to one at the bottom.
  logic [FramesW-1:0] load_frames;
  logic               sched_ok;
  logic [VW-1:0]      sv_idx;
  logic [SourceW-1:0] pad_src [PadCount];

  always_comb begin
    if (prod_q[ProdW-1:FramesW+QFracW] != '0) begin
      load_frames = '1;
    end else if (prod_q[FramesW+QFracW-1:QFracW] == '0) begin
      load_frames = FramesW'(1);
    end else begin
      load_frames = prod_q[FramesW+QFracW-1:QFracW];
    end
  end

  assign sched_ok = (pad_q[1] == 1'b0)
                    && ({1'b0, voice_q} < (VoiceW+1)'(NUM_VOICES));
  assign sv_idx   = voice_q[VW-1:0];
  assign pad_src[0] = first_src_q;
  assign pad_src[1] = second_src_q;

  // Walk counter and the pending expiry, held back one hit so that the
  // final note-off of an advance can carry the last flag.
  logic               wpad_q;
  logic [VW-1:0]      wvoice_q;
  logic               pend_v_q;
  logic               pend_pad_q;
  logic [VW-1:0]      pend_voice_q;
  logic [FramesW-1:0] frames_q [PadCount][NUM_VOICES];
  logic [FramesW-1:0] cur;
  logic               hit;

  assign cur = frames_q[wpad_q][wvoice_q];
  assign hit = (cur != '0) && (cur <= elapsed_q);
  assign status_o.walk_end = wpad_q && (wvoice_q == LastVoice);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wpad_q   <= 1'b0;
      wvoice_q <= '0;
      pend_v_q <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        wpad_q   <= 1'b0;
        wvoice_q <= '0;
        pend_v_q <= 1'b0;
      end else if (cmd_i.walk) begin
        if (wvoice_q == LastVoice) begin
          wvoice_q <= '0;
          wpad_q   <= 1'b1;
        end else begin
          wvoice_q <= wvoice_q + VW'(1);
        end
        if (hit) begin
          pend_v_q <= 1'b1;
        end
      end else if (cmd_i.flush) begin
        pend_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.walk && hit) begin
      pend_pad_q   <= wpad_q;
      pend_voice_q <= wvoice_q;
    end
  end

  // Countdown table.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < PadCount; p++) begin
        for (int v = 0; v < NUM_VOICES; v++) begin
          frames_q[p][v] <= '0;
        end
      end
    end else begin
      if (cmd_i.exec) begin
        if ((kind_q == KIND_SCHEDULE) && sched_ok) begin
          for (int p = 0; p < PadCount; p++) begin
            frames_q[p][sv_idx] <= '0;
          end
          if (prod_q != '0) begin
            frames_q[pad_q[0]][sv_idx] <= load_frames;
          end
        end
        if (kind_q == KIND_CLEAR) begin
          for (int p = 0; p < PadCount; p++) begin
            if ((src_q == '0) || (src_q == pad_src[p])) begin
              for (int v = 0; v < NUM_VOICES; v++) begin
                frames_q[p][v] <= '0;
              end
            end
          end
        end
      end
      if (cmd_i.walk && (cur != '0)) begin
        frames_q[wpad_q][wvoice_q] <= hit ? '0 : (cur - elapsed_q);
      end
    end
  end

  // Result register.
  logic              res_valid_q, res_valid_d;
  logic              fired_q, fired_d;
  logic              fpad_q, fpad_d;
  logic [VoiceW-1:0] fvoice_q, fvoice_d;
  logic              last_q, last_d;

  always_comb begin
    res_valid_d = cmd_i.exec || cmd_i.flush || (cmd_i.walk && hit && pend_v_q);
    fired_d     = 1'b0;
    fpad_d      = 1'b0;
    fvoice_d    = '0;
    last_d      = cmd_i.exec || cmd_i.flush;
    if ((cmd_i.walk || cmd_i.flush) && pend_v_q) begin
      fired_d  = 1'b1;
      fpad_d   = pend_pad_q;
      fvoice_d = VoiceW'(pend_voice_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fired_q  <= fired_d;
    fpad_q   <= fpad_d;
    fvoice_q <= fvoice_d;
    last_q   <= last_d;
  end

  assign result_valid_o = res_valid_q;
  assign fired_o        = fired_q;
  assign fired_pad_o    = fpad_q;
  assign fired_voice_o  = fvoice_q;
  assign last_o         = last_q;

endmodule
